>>> rtl/nmea_pkg.sv
// ----------------------------------------------------------------------------
// nmea_pkg
// Shared constants and character helpers for the GPRMC time sentence core.
// ----------------------------------------------------------------------------
package nmea_pkg;

  // Sentence geometry
  localparam int unsigned BODY_LEN = 70;
  localparam int unsigned SENT_LEN = 74;
  localparam int unsigned IDX_W    = 7;

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [7:0]       char_t;

  // Byte positions with special content
  localparam idx_t IDX_HR_T   = idx_t'(7);
  localparam idx_t IDX_HR_U   = idx_t'(8);
  localparam idx_t IDX_MIN_T  = idx_t'(9);
  localparam idx_t IDX_MIN_U  = idx_t'(10);
  localparam idx_t IDX_SEC_T  = idx_t'(11);
  localparam idx_t IDX_SEC_U  = idx_t'(12);
  localparam idx_t IDX_CEN_T  = idx_t'(14);
  localparam idx_t IDX_CEN_U  = idx_t'(15);
  localparam idx_t IDX_STAR   = idx_t'(BODY_LEN - 1);
  localparam idx_t IDX_SUM_HI = idx_t'(BODY_LEN);
  localparam idx_t IDX_SUM_LO = idx_t'(BODY_LEN + 1);
  localparam idx_t IDX_CR     = idx_t'(BODY_LEN + 2);
  localparam idx_t IDX_LF     = idx_t'(SENT_LEN - 1);
  localparam idx_t IDX_FIRST  = idx_t'(1);

  localparam char_t CH_DOLLAR = 8'h24;
  localparam char_t CH_CR     = 8'h0D;
  localparam char_t CH_LF     = 8'h0A;
  localparam char_t CH_ZERO   = 8'h30;

  // Reciprocal multipliers (round-up method, exact over the stated input range)
  localparam logic [28:0] RCP_1000 = 29'd274877907; // x/1000, x < 2^32, >> 38
  localparam logic [23:0] RCP_3600 = 24'd9544372;   // x/3600, x < 2^23, >> 35
  localparam logic [10:0] RCP_10W  = 11'd1639;      // x/10,   x < 2^10, >> 14
  localparam logic [8:0]  RCP_3    = 9'd342;        // x/3,    x < 2^8,  >> 10
  localparam logic [12:0] RCP_60   = 13'd4370;      // x/60,   x < 2^12, >> 18
  localparam logic [7:0]  RCP_10N  = 8'd205;        // x/10,   x < 2^7,  >> 11

  localparam logic [8*BODY_LEN-1:0] BODY_TEXT =
    "$GPRMC,000000.00,A,4546.40891,N,12639.65641,E,1.045,328.42,191118,,,A*";

  // Fixed text of the sentence body, first character at index 0
  function automatic char_t body_char(input idx_t idx);
    int unsigned pos;
    pos = BODY_LEN - 1 - int'(idx);
    if (int'(idx) < BODY_LEN) begin
      return BODY_TEXT[8*pos +: 8];
    end
    return 8'h00;
  endfunction

  // Uppercase hex digit
  function automatic char_t hex_char(input logic [3:0] nib);
    if (nib < 4'd10) begin
      return 8'h30 + {4'h0, nib};
    end
    return 8'h37 + {4'h0, nib};
  endfunction

  // Tens digit of a value below 100
  function automatic logic [3:0] dec_tens(input logic [6:0] v);
    logic [14:0] p;
    p = 15'(v) * 15'(RCP_10N);
    return p[14:11];
  endfunction

  // Units digit of a value below 100
  function automatic logic [3:0] dec_units(input logic [6:0] v);
    logic [3:0] t;
    logic [6:0] tk;
    t  = dec_tens(v);
    tk = (7'(t) << 3) + (7'(t) << 1);
    return 4'(v - tk);
  endfunction

endpackage

>>> rtl/nmea_time_sentence_generator_core.sv
// A ready request that yields a byte passes the input register, then the output
// register, before it shows on out_tdata. One request per cycle unless the output stalls.
// Time conversion runs in a six-stage pipeline behind the latched millisecond
// count; it completes before the first time digit (byte seven) is reached.
// Reset: rst_n synchronous, active low; clears input valid, pending, pending time,
// sending, index, checksum and output valid. Other data registers are not reset.
// ----------------------------------------------------------------------------
// nmea_time_sentence_generator_core
// Emits the 74-byte GPRMC time sentence one byte per transmitter-ready request,
// using the latest timer update as the time of day.
// ----------------------------------------------------------------------------
module nmea_time_sentence_generator_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] time_ms
  input  logic        in_tuser,   // [0] mode
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [7:0] tx_byte
  output logic        out_tlast
);

  // Input register
  logic        s0_valid_r;
  logic        s0_mode_r;
  logic [31:0] s0_ms_r;
  logic        go;

  // Control state
  logic                 pending_r, pending_nxt;
  logic [31:0]          pend_ms_r, pend_ms_nxt;
  logic                 sending_r, sending_nxt;
  nmea_pkg::idx_t       idx_r, idx_nxt;
  logic [7:0]           xor_r, xor_nxt;
  logic [31:0]          lat_ms_r, lat_ms_nxt;
  logic                 start;

  // Output register
  logic                 out_tvalid_r, out_tvalid_nxt;
  logic [7:0]           out_tdata_r, out_tdata_nxt;
  logic                 out_tlast_r, out_tlast_nxt;
  logic                 emit;
  nmea_pkg::char_t      cur_char;

  // Conversion pipeline
  logic [60:0] p1;
  logic [22:0] s1_q_r;
  logic [31:0] s1_ms_r;
  logic [31:0] q_k;
  logic [46:0] p2;
  logic [9:0]  s2_rem_r;
  logic [10:0] s2_ht_r;
  logic [22:0] s2_q_r;
  logic [22:0] ht_k;
  logic [20:0] p3;
  logic [17:0] p3h;
  logic [7:0]  h8;
  logic [7:0]  d3;
  logic [7:0]  r3;
  logic [11:0] s3_sh_r;
  logic [6:0]  s3_cen_r;
  logic [4:0]  s3_hr_r;
  logic [24:0] p4;
  logic [5:0]  s4_min_r;
  logic [11:0] s4_sh_r;
  logic [6:0]  s4_cen_r;
  logic [4:0]  s4_hr_r;
  logic [11:0] min_k;
  logic [5:0]  s5_sec_r;
  logic [5:0]  s5_min_r;
  logic [6:0]  s5_cen_r;
  logic [4:0]  s5_hr_r;
  logic [7:0][3:0] s6_dig_r;

  assign go        = s0_valid_r && (!out_tvalid_r || out_tready);
  assign in_tready = !s0_valid_r || go;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r <= 1'b0;
    end else if (in_tready) begin
      s0_valid_r <= in_tvalid;
    end
    if (in_tvalid && in_tready) begin
      s0_mode_r <= in_tuser;
      s0_ms_r   <= in_tdata;
    end
  end

  // Character at the current index
  always_comb begin
    case (idx_r)
      nmea_pkg::IDX_HR_T:   cur_char = {4'h3, s6_dig_r[0]};
      nmea_pkg::IDX_HR_U:   cur_char = {4'h3, s6_dig_r[1]};
      nmea_pkg::IDX_MIN_T:  cur_char = {4'h3, s6_dig_r[2]};
      nmea_pkg::IDX_MIN_U:  cur_char = {4'h3, s6_dig_r[3]};
      nmea_pkg::IDX_SEC_T:  cur_char = {4'h3, s6_dig_r[4]};
      nmea_pkg::IDX_SEC_U:  cur_char = {4'h3, s6_dig_r[5]};
      nmea_pkg::IDX_CEN_T:  cur_char = {4'h3, s6_dig_r[6]};
      nmea_pkg::IDX_CEN_U:  cur_char = {4'h3, s6_dig_r[7]};
      nmea_pkg::IDX_SUM_HI: cur_char = nmea_pkg::hex_char(xor_r[7:4]);
      nmea_pkg::IDX_SUM_LO: cur_char = nmea_pkg::hex_char(xor_r[3:0]);
      nmea_pkg::IDX_CR:     cur_char = nmea_pkg::CH_CR;
      nmea_pkg::IDX_LF:     cur_char = nmea_pkg::CH_LF;
      default:              cur_char = nmea_pkg::body_char(idx_r);
    endcase
  end

  // Request handling: timer update, sentence start, next byte
  always_comb begin
    pending_nxt    = pending_r;
    pend_ms_nxt    = pend_ms_r;
    sending_nxt    = sending_r;
    idx_nxt        = idx_r;
    xor_nxt        = xor_r;
    lat_ms_nxt     = lat_ms_r;
    emit           = 1'b0;
    start          = 1'b0;
    out_tdata_nxt  = out_tdata_r;
    out_tlast_nxt  = out_tlast_r;
    if (go) begin
      if (!s0_mode_r) begin
        pending_nxt = 1'b1;
        pend_ms_nxt = s0_ms_r;
      end else if (!sending_r) begin
        if (pending_r) begin
          // '$' goes out at once, time fields come later from the pipeline
          start         = 1'b1;
          emit          = 1'b1;
          pending_nxt   = 1'b0;
          sending_nxt   = 1'b1;
          lat_ms_nxt    = pend_ms_r;
          idx_nxt       = nmea_pkg::IDX_FIRST;
          xor_nxt       = 8'h00;
          out_tdata_nxt = nmea_pkg::CH_DOLLAR;
          out_tlast_nxt = 1'b0;
        end
      end else begin
        emit          = 1'b1;
        out_tdata_nxt = cur_char;
        if (idx_r >= nmea_pkg::IDX_FIRST && idx_r < nmea_pkg::IDX_STAR) begin
          xor_nxt = xor_r ^ cur_char;
        end
        if (idx_r >= nmea_pkg::IDX_LF) begin
          out_tlast_nxt = 1'b1;
          sending_nxt   = 1'b0;
          idx_nxt       = '0;
        end else begin
          out_tlast_nxt = 1'b0;
          idx_nxt       = idx_r + nmea_pkg::idx_t'(1);
        end
      end
    end
    out_tvalid_nxt = emit || (out_tvalid_r && !out_tready);
  end

  // Control and output registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r    <= 1'b0;
      pend_ms_r    <= '0;
      sending_r    <= 1'b0;
      idx_r        <= '0;
      xor_r        <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      pending_r    <= pending_nxt;
      pend_ms_r    <= pend_ms_nxt;
      sending_r    <= sending_nxt;
      idx_r        <= idx_nxt;
      xor_r        <= xor_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
    lat_ms_r    <= lat_ms_nxt;
    out_tdata_r <= out_tdata_nxt;
    out_tlast_r <= out_tlast_nxt;
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tlast  = out_tlast_r;

  // Time conversion arithmetic
  always_comb begin
    p1    = 61'(lat_ms_r) * 61'(nmea_pkg::RCP_1000);
    q_k   = 32'(s1_q_r) * 32'd1000;
    p2    = 47'(s1_q_r) * 47'(nmea_pkg::RCP_3600);
    ht_k  = 23'(s2_ht_r) * 23'd3600;
    p3    = 21'(s2_rem_r) * 21'(nmea_pkg::RCP_10W);
    // hours modulo 24 = (hours/8 mod 3) * 8 + hours mod 8
    h8    = s2_ht_r[10:3];
    p3h   = 18'(h8) * 18'(nmea_pkg::RCP_3);
    d3    = p3h[17:10];
    r3    = h8 - (d3 + (d3 << 1));
    p4    = 25'(s3_sh_r) * 25'(nmea_pkg::RCP_60);
    min_k = (12'(s4_min_r) << 6) - (12'(s4_min_r) << 2);
  end

  // Conversion pipeline registers
  always_ff @(posedge clk) begin
    // ms / 1000
    s1_q_r   <= p1[60:38];
    s1_ms_r  <= lat_ms_r;
    // ms mod 1000, whole hours
    s2_rem_r <= 10'(s1_ms_r - q_k);
    s2_ht_r  <= p2[45:35];
    s2_q_r   <= s1_q_r;
    // seconds within the hour, hundredths, hour of day
    s3_sh_r  <= 12'(s2_q_r - ht_k);
    s3_cen_r <= p3[20:14];
    s3_hr_r  <= {r3[1:0], s2_ht_r[2:0]};
    // minutes
    s4_min_r <= p4[23:18];
    s4_sh_r  <= s3_sh_r;
    s4_cen_r <= s3_cen_r;
    s4_hr_r  <= s3_hr_r;
    // seconds
    s5_sec_r <= 6'(s4_sh_r - min_k);
    s5_min_r <= s4_min_r;
    s5_cen_r <= s4_cen_r;
    s5_hr_r  <= s4_hr_r;
    // decimal digits
    s6_dig_r[0] <= nmea_pkg::dec_tens(7'(s5_hr_r));
    s6_dig_r[1] <= nmea_pkg::dec_units(7'(s5_hr_r));
    s6_dig_r[2] <= nmea_pkg::dec_tens(7'(s5_min_r));
    s6_dig_r[3] <= nmea_pkg::dec_units(7'(s5_min_r));
    s6_dig_r[4] <= nmea_pkg::dec_tens(7'(s5_sec_r));
    s6_dig_r[5] <= nmea_pkg::dec_units(7'(s5_sec_r));
    s6_dig_r[6] <= nmea_pkg::dec_tens(s5_cen_r);
    s6_dig_r[7] <= nmea_pkg::dec_units(s5_cen_r);
  end

`ifndef SYNTHESIS
  // Index stays inside the sentence while sending
  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    sending_r |-> (idx_r >= nmea_pkg::IDX_FIRST && idx_r <= nmea_pkg::IDX_LF))
    else $error("byte index out of range while sending");

  // Idle means index back at zero
  a_idle_idx: assert property (@(posedge clk) disable iff (!rst_n)
    !sending_r |-> (idx_r == '0))
    else $error("byte index not cleared while idle");

  // A start puts '$' in the output register and enters sending
  a_start: assert property (@(posedge clk) disable iff (!rst_n)
    start |=> (sending_r && out_tvalid_r && out_tdata_r == nmea_pkg::CH_DOLLAR
               && !pending_r))
    else $error("sentence start did not emit the leading character");

  // Last marker only on the line feed
  a_last_lf: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid_r && out_tlast_r) |-> (out_tdata_r == nmea_pkg::CH_LF && !sending_r))
    else $error("last marker on a byte other than the final line feed");
`endif

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the GPRMC time sentence core. A directed table opens
// the run (idle ready, overwritten updates, the head of a sentence at midnight,
// an update landing mid-sentence), then random traffic of updates and ready
// requests is pushed through with bursty input and a stalling receiver. Every
// byte is compared against the table's expected bytes or a behavioural sentence predictor.
// ----------------------------------------------------------------------------
module tb_top;

  // Request kinds carried on in_tuser
  localparam bit MODE_TIMER = 1'b0;
  localparam bit MODE_READY = 1'b1;

  // Receiver behaviour styles
  localparam int RX_OPEN   = 0;
  localparam int RX_CHOPPY = 1;
  localparam int RX_BLOCKY = 2;

  localparam int RANDOM_ITEMS = 1230;
  localparam int DRAIN_CYCLES = 12;
  localparam int CYCLE_LIMIT  = 200000;

  typedef struct packed {
    logic [7:0] ch;
    logic       lst;
  } sent_char_t;

  typedef struct {
    bit          mode;
    logic [31:0] ms;
    bit          typed;
    bit          has_res;
    logic [7:0]  ch;
    bit          lst;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = 32'h0;   // [31:0] time_ms
  logic        in_tuser = 1'b0;    // [0] mode
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;          // [7:0] tx_byte
  logic        out_tlast;

  nmea_time_sentence_generator_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Sentence predictor
  // --------------------------------------------------------------------------
  string body_txt = "$GPRMC,000000.00,A,4546.40891,N,12639.65641,E,1.045,328.42,191118,,,A*";
  string hex_txt  = "0123456789ABCDEF";

  bit             upd_pending = 1'b0;
  logic [31:0]    upd_ms      = 32'h0;
  bit             in_sentence = 1'b0;
  int unsigned    t_hh, t_mm, t_ss, t_cc;
  nmea_pkg::idx_t char_pos    = '0;
  logic [7:0]     csum        = 8'h00;

  sent_char_t  sentence_q[$];
  dir_row_t    dir_rows[$];
  int          errors = 0;
  int unsigned cycle_cnt = 0;

  function automatic logic [7:0] digit(input int unsigned v);
    return nmea_pkg::CH_ZERO + 8'(v % 10);
  endfunction

  function automatic logic [7:0] sentence_char(input nmea_pkg::idx_t idx);
    case (idx)
      nmea_pkg::IDX_HR_T:   return digit(t_hh / 10);
      nmea_pkg::IDX_HR_U:   return digit(t_hh);
      nmea_pkg::IDX_MIN_T:  return digit(t_mm / 10);
      nmea_pkg::IDX_MIN_U:  return digit(t_mm);
      nmea_pkg::IDX_SEC_T:  return digit(t_ss / 10);
      nmea_pkg::IDX_SEC_U:  return digit(t_ss);
      nmea_pkg::IDX_CEN_T:  return digit(t_cc / 10);
      nmea_pkg::IDX_CEN_U:  return digit(t_cc);
      nmea_pkg::IDX_SUM_HI: return hex_txt[int'(csum[7:4])];
      nmea_pkg::IDX_SUM_LO: return hex_txt[int'(csum[3:0])];
      nmea_pkg::IDX_CR:     return nmea_pkg::CH_CR;
      nmea_pkg::IDX_LF:     return nmea_pkg::CH_LF;
      default: begin
        if (int'(idx) < nmea_pkg::BODY_LEN) return body_txt[int'(idx)];
        return 8'h00;
      end
    endcase
  endfunction

  // Advance the predictor by one accepted request
  task automatic gprmc_step(input bit mode, input logic [31:0] ms,
                            output bit got, output sent_char_t res);
    int unsigned secs;
    logic [7:0]  c;
    got = 1'b0;
    res = '0;
    if (mode == MODE_TIMER) begin
      upd_pending = 1'b1;
      upd_ms      = ms;
    end else begin
      // Idle with an update waiting: latch the time and open a sentence
      if (!in_sentence && upd_pending) begin
        secs        = (upd_ms / 1000) % 86400;
        t_hh        = secs / 3600;
        t_mm        = (secs % 3600) / 60;
        t_ss        = secs % 60;
        t_cc        = (upd_ms % 1000) / 10;
        upd_pending = 1'b0;
        in_sentence = 1'b1;
        char_pos    = '0;
        csum        = 8'h00;
      end
      if (in_sentence) begin
        c = sentence_char(char_pos);
        if (char_pos >= nmea_pkg::IDX_FIRST && char_pos < nmea_pkg::IDX_STAR)
          csum = csum ^ c;
        res.ch  = c;
        res.lst = (char_pos == nmea_pkg::IDX_LF);
        if (char_pos == nmea_pkg::IDX_LF) begin
          in_sentence = 1'b0;
          char_pos    = '0;
        end else begin
          char_pos = char_pos + 1'b1;
        end
        got = 1'b1;
      end
    end
  endtask

  // Awkward millisecond values: range ends and carry points
  function automatic logic [31:0] corner_ms(input int k);
    case (k)
      0: return 32'd0;
      1: return 32'hFFFF_FFFF;
      2: return 32'd86399999;
      3: return 32'd86400000;
      4: return 32'd3599999;
      5: return 32'd999;
      6: return 32'd59990;
      default: return 32'd45296780;
    endcase
  endfunction

  task automatic add_row(input bit mode, input logic [31:0] ms, input bit typed,
                         input bit has_res, input logic [7:0] ch, input bit lst);
    dir_row_t r;
    r.mode    = mode;
    r.ms      = ms;
    r.typed   = typed;
    r.has_res = has_res;
    r.ch      = ch;
    r.lst     = lst;
    dir_rows.push_back(r);
  endtask

  // --------------------------------------------------------------------------
  // Request driver: bursts of random length with random gaps
  // --------------------------------------------------------------------------
  int burst_left = 0;

  task automatic send_request(input bit mode, input logic [31:0] ms);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 48);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left = burst_left - 1;
    in_tvalid <= 1'b1;
    in_tuser  <= mode;
    in_tdata  <= ms;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Receiver: switches between open, choppy and blocky stalling
  // --------------------------------------------------------------------------
  int       rx_style = RX_OPEN;
  int       rx_hold  = 0;
  bit [3:0] rx_tick  = '0;

  always @(posedge clk) begin
    rx_tick <= rx_tick + 1'b1;
    if (rx_hold == 0) begin
      rx_style <= $urandom_range(RX_OPEN, RX_BLOCKY);
      rx_hold  <= $urandom_range(50, 300);
    end else begin
      rx_hold <= rx_hold - 1;
    end
    case (rx_style)
      RX_OPEN:   out_tready <= 1'b1;
      RX_CHOPPY: out_tready <= ($urandom_range(0, 3) != 0);
      default:   out_tready <= (rx_tick[3:2] != 2'b00);
    endcase
  end

  // --------------------------------------------------------------------------
  // Result checker
  // --------------------------------------------------------------------------
  sent_char_t want;

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (sentence_q.size() == 0) begin
        $display("%0t: unexpected byte %h last %b", $time, out_tdata, out_tlast);
        errors = errors + 1;
      end else begin
        want = sentence_q.pop_front();
        if (out_tdata !== want.ch) begin
          $display("%0t: tx_byte expected %h actual %h", $time, want.ch, out_tdata);
          errors = errors + 1;
        end
        if (out_tlast !== want.lst) begin
          $display("%0t: last expected %b actual %b", $time, want.lst, out_tlast);
          errors = errors + 1;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) cycle_cnt <= cycle_cnt + 1;

  initial begin
    wait (cycle_cnt >= CYCLE_LIMIT);
    $display("Regression FAIL");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin
    bit          got;
    sent_char_t  res;
    bit          mode;
    logic [31:0] ms;
    int          counted;

    // Ready straight after reset: nothing to send
    add_row(MODE_READY, 32'hFFFF_FFFF, 1, 0, 8'h00, 0);
    // Update at the top of the range, then overwritten by midnight
    add_row(MODE_TIMER, 32'hFFFF_FFFF, 1, 0, 8'h00, 0);
    add_row(MODE_TIMER, 32'h0000_0000, 1, 0, 8'h00, 0);
    // Head of the sentence at 00:00:00.00
    add_row(MODE_READY, 32'h0000_0000, 1, 1, nmea_pkg::CH_DOLLAR, 0);
    add_row(MODE_READY, 32'hFFFF_FFFF, 1, 1, "G", 0);
    add_row(MODE_READY, 32'h0000_0000, 1, 1, "P", 0);
    add_row(MODE_READY, 32'hFFFF_FFFF, 1, 1, "R", 0);
    add_row(MODE_READY, 32'h0000_0000, 1, 1, "M", 0);
    add_row(MODE_READY, 32'hFFFF_FFFF, 1, 1, "C", 0);
    add_row(MODE_READY, 32'h0000_0000, 1, 1, ",", 0);
    // Update lands mid-sentence; the latched midnight time must hold
    add_row(MODE_TIMER, 32'd86399999, 0, 0, 8'h00, 0);
    add_row(MODE_READY, 32'hFFFF_FFFF, 1, 1, nmea_pkg::CH_ZERO, 0);
    add_row(MODE_READY, 32'h0000_0000, 1, 1, nmea_pkg::CH_ZERO, 0);
    add_row(MODE_READY, 32'hFFFF_FFFF, 1, 1, nmea_pkg::CH_ZERO, 0);
    add_row(MODE_READY, 32'h0000_0000, 1, 1, nmea_pkg::CH_ZERO, 0);
    add_row(MODE_READY, 32'hFFFF_FFFF, 1, 1, nmea_pkg::CH_ZERO, 0);
    add_row(MODE_READY, 32'h0000_0000, 1, 1, nmea_pkg::CH_ZERO, 0);
    add_row(MODE_READY, 32'hFFFF_FFFF, 1, 1, ".", 0);
    add_row(MODE_READY, 32'h0000_0000, 1, 1, nmea_pkg::CH_ZERO, 0);
    add_row(MODE_READY, 32'hFFFF_FFFF, 1, 1, nmea_pkg::CH_ZERO, 0);
    // Second update mid-sentence overwrites the first
    add_row(MODE_TIMER, 32'd86400000, 0, 0, 8'h00, 0);
    add_row(MODE_READY, 32'h0000_0000, 0, 0, 8'h00, 0);
    add_row(MODE_READY, 32'hFFFF_FFFF, 0, 0, 8'h00, 0);

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Directed table
    foreach (dir_rows[i]) begin
      send_request(dir_rows[i].mode, dir_rows[i].ms);
      gprmc_step(dir_rows[i].mode, dir_rows[i].ms, got, res);
      if (dir_rows[i].typed) begin
        if (dir_rows[i].has_res) begin
          res.ch  = dir_rows[i].ch;
          res.lst = dir_rows[i].lst;
          sentence_q.push_back(res);
        end
      end else if (got) begin
        sentence_q.push_back(res);
      end
    end

    // Random traffic: mostly whole sentences, with stray updates and idle readies
    counted = 0;
    while (counted < RANDOM_ITEMS) begin
      if (!in_sentence && !upd_pending)
        mode = ($urandom_range(0, 4) != 0) ? MODE_TIMER : MODE_READY;
      else
        mode = ($urandom_range(0, 19) == 0) ? MODE_TIMER : MODE_READY;
      ms = ($urandom_range(0, 3) == 0) ? corner_ms($urandom_range(0, 7)) : $urandom;
      send_request(mode, ms);
      gprmc_step(mode, ms, got, res);
      if (got) sentence_q.push_back(res);
      if (mode == MODE_TIMER || got) counted = counted + 1;
    end

    // Drain
    in_tvalid <= 1'b0;
    while (sentence_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && sentence_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
